### rtl/pmst_pkg.sv
// Package for the Prim spanning tree block: field widths, op codes,
// sequencer states and the control struct of the shared compare unit.
// No dependencies.
package pmst_pkg;

    // Fixed field widths of the channels and the configuration register.
    localparam int OP_W      = 2;
    localparam int NODE_ID_W = 4;
    localparam int EDGE_W    = 16;
    localparam int COST_W    = 20;
    localparam int CFG_W     = 5;

    localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

    // Reset value of the node count register.
    localparam logic [CFG_W-1:0] NODE_COUNT_RST = 5'd2;

    // Input op codes; code 3 is accepted and ignored.
    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_START = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WR2,
        ST_SCAN,
        ST_SCAN_END,
        ST_PICK,
        ST_LOAD
    } state_t;

    // Control of the shared minimum search unit.
    typedef struct packed {
        logic init;
        logic sample;
    } cmp_ctl_t;

endpackage

### rtl/pmst_if.sv
// Valid/ready channel interfaces for the input and result beats.
// Depends on pmst_pkg for the payload widths.
interface pmst_in_if;
    logic                            valid;
    logic                            ready;
    logic [pmst_pkg::OP_W-1:0]       op;
    logic [pmst_pkg::NODE_ID_W-1:0]  node_a;
    logic [pmst_pkg::NODE_ID_W-1:0]  node_b;
    logic [pmst_pkg::EDGE_W-1:0]     edge_weight;

    modport source (output valid, op, node_a, node_b, edge_weight, input ready);
    modport sink   (input valid, op, node_a, node_b, edge_weight, output ready);
endinterface

interface pmst_out_if;
    logic                            valid;
    logic                            ready;
    logic [pmst_pkg::NODE_ID_W-1:0]  from_node;
    logic [pmst_pkg::NODE_ID_W-1:0]  to_node;
    logic [pmst_pkg::EDGE_W-1:0]     chosen_weight;
    logic [pmst_pkg::COST_W-1:0]     total_cost;
    logic                            no_edge;
    logic                            last;

    modport source (output valid, from_node, to_node, chosen_weight, total_cost,
                    no_edge, last, input ready);
    modport sink   (input valid, from_node, to_node, chosen_weight, total_cost,
                    no_edge, last, output ready);
endinterface

### rtl/pmst_wmem.sv
// Weight matrix memory: one write port and one read port with registered
// read data. No dependencies.
module pmst_wmem #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data register holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### rtl/pmst_min_unit.sv
// Shared minimum search unit: keeps the smallest weight seen in a scan and
// where it was found; the first of equal weights wins. Depends on pmst_pkg.
module pmst_min_unit #(
    parameter int NODE_W = 4,
    parameter int DATA_W = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  pmst_pkg::cmp_ctl_t ctl,
    input  logic [DATA_W-1:0]  sample_w,
    input  logic [NODE_W-1:0]  sample_row,
    input  logic [NODE_W-1:0]  sample_col,
    output logic               found,
    output logic [NODE_W-1:0]  best_row,
    output logic [NODE_W-1:0]  best_col
);

    logic              found_reg, found_next;
    logic [DATA_W-1:0] best_reg, best_next;
    logic [NODE_W-1:0] row_reg, row_next;
    logic [NODE_W-1:0] col_reg, col_next;

    // One compare per cycle against the running best.
    always_comb
    begin
        found_next = found_reg;
        best_next  = best_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        priority if (ctl.init)
        begin
            found_next = 1'b0;
            best_next  = '0;
            row_next   = '0;
            col_next   = '0;
        end
        else if (ctl.sample && (!found_reg || (sample_w < best_reg)))
        begin
            found_next = 1'b1;
            best_next  = sample_w;
            row_next   = sample_row;
            col_next   = sample_col;
        end
        else
        begin
            // The running best holds.
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg <= 1'b0;
            row_reg   <= '0;
            col_reg   <= '0;
        end
        else
        begin
            found_reg <= found_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
    end

    assign found    = found_reg;
    assign best_row = row_reg;
    assign best_col = col_reg;

endmodule

### rtl/prim_mst_adjacency_matrix.sv
// Prim minimum spanning tree over a stored weight matrix.
// A write beat with in-range nodes stores the weight at (a,b), then at (b,a); a clear beat zeroes
// the matrix. A start beat gives min(node_count, MAX_NODES)-1 result beats, each after a scan of
// the n*n entries (one matrix entry per cycle through the single read port) plus any output stall.
// Reset: asynchronous, active low; the matrix is then zeroed by a clearing pass over all
// 2^(2*NODE_W) entries (256 by default) before the first input beat.
module prim_mst_adjacency_matrix #(
    parameter int MAX_NODES   = 16,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [pmst_pkg::CFG_W-1:0]   cfg_wr_data,
    pmst_in_if.sink                      in_ch,
    pmst_out_if.source                   out_ch
);

    localparam int NODE_W = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
    localparam int ADDR_W = 2 * NODE_W;
    localparam int SUM_W  = ((WEIGHT_BITS > pmst_pkg::COST_W) ? WEIGHT_BITS
                                                               : pmst_pkg::COST_W) + 1;

    typedef logic [NODE_W-1:0]      node_t;
    typedef logic [ADDR_W-1:0]      addr_t;
    typedef logic [WEIGHT_BITS-1:0] weight_t;
    typedef logic [SUM_W-1:0]       sum_t;

    pmst_pkg::state_t state_reg, state_next;

    logic [pmst_pkg::CFG_W-1:0]  node_count_reg;
    addr_t                       clr_addr_reg, clr_addr_next;
    node_t                       wr_a_reg, wr_a_next;
    node_t                       wr_b_reg, wr_b_next;
    weight_t                     wr_w_reg, wr_w_next;
    node_t                       i_reg, i_next;
    node_t                       j_reg, j_next;
    node_t                       last_idx_reg, last_idx_next;
    node_t                       step_reg, step_next;
    logic [MAX_NODES-1:0]        visited_reg, visited_next;
    logic [pmst_pkg::COST_W-1:0] cost_reg, cost_next;

    // Read pipeline tags that travel with the registered memory data.
    logic  q_valid_reg, q_valid_next;
    logic  q_qual_reg, q_qual_next;
    node_t q_row_reg, q_row_next;
    node_t q_col_reg, q_col_next;

    // Output register.
    logic                           out_valid_reg, out_valid_next;
    logic [pmst_pkg::NODE_ID_W-1:0] out_from_reg, out_from_next;
    logic [pmst_pkg::NODE_ID_W-1:0] out_to_reg, out_to_next;
    logic [pmst_pkg::EDGE_W-1:0]    out_w_reg, out_w_next;
    logic [pmst_pkg::COST_W-1:0]    out_cost_reg, out_cost_next;
    logic                           out_none_reg, out_none_next;
    logic                           out_last_reg, out_last_next;

    logic    mem_we, mem_re;
    addr_t   mem_waddr, mem_raddr;
    weight_t mem_wdata, mem_rdata;

    pmst_pkg::cmp_ctl_t cmp_ctl;
    logic               best_found;
    node_t              best_row, best_col;

    logic  in_acc;
    logic  in_range;
    logic  out_free;
    logic  scan_done;
    logic  run_ok;
    node_t start_last;
    logic  step_last;
    sum_t  cost_sum;

    assign in_acc    = in_ch.valid && in_ch.ready;
    assign in_range  = (in_ch.node_a < MAX_NODES) && (in_ch.node_b < MAX_NODES);
    assign out_free  = !out_valid_reg || out_ch.ready;
    assign scan_done = (i_reg == last_idx_reg) && (j_reg == last_idx_reg);
    assign run_ok    = (node_count_reg >= pmst_pkg::CFG_W'(2));
    assign step_last = (step_reg == (last_idx_reg - node_t'(1)));
    assign cost_sum  = sum_t'(cost_reg) + sum_t'(mem_rdata);

    // Last node index of the effective node count, saturated to the built capacity.
    always_comb
    begin
        if (node_count_reg > MAX_NODES)
        begin
            start_last = node_t'(MAX_NODES - 1);
        end
        else
        begin
            start_last = node_t'(node_count_reg - pmst_pkg::CFG_W'(1));
        end
    end

    pmst_wmem #(
        .ADDR_W (ADDR_W),
        .DATA_W (WEIGHT_BITS)
    ) u_wmem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pmst_min_unit #(
        .NODE_W (NODE_W),
        .DATA_W (WEIGHT_BITS)
    ) u_min (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (cmp_ctl),
        .sample_w   (mem_rdata),
        .sample_row (q_row_reg),
        .sample_col (q_col_reg),
        .found      (best_found),
        .best_row   (best_row),
        .best_col   (best_col)
    );

    // Next state of the sequencer.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pmst_pkg::ST_CLEAR:
            begin
                if (clr_addr_reg == '1)
                begin
                    state_next = pmst_pkg::ST_IDLE;
                end
            end
            pmst_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (in_ch.op == pmst_pkg::OP_WRITE)
                    begin
                        if (in_range)
                        begin
                            state_next = pmst_pkg::ST_WR2;
                        end
                    end
                    else if (in_ch.op == pmst_pkg::OP_START)
                    begin
                        if (run_ok)
                        begin
                            state_next = pmst_pkg::ST_SCAN;
                        end
                    end
                    else if (in_ch.op == pmst_pkg::OP_CLEAR)
                    begin
                        state_next = pmst_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        // The unused op code is dropped.
                    end
                end
            end
            pmst_pkg::ST_WR2:
            begin
                state_next = pmst_pkg::ST_IDLE;
            end
            pmst_pkg::ST_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = pmst_pkg::ST_SCAN_END;
                end
            end
            pmst_pkg::ST_SCAN_END:
            begin
                state_next = pmst_pkg::ST_PICK;
            end
            pmst_pkg::ST_PICK:
            begin
                state_next = pmst_pkg::ST_LOAD;
            end
            pmst_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    state_next = step_last ? pmst_pkg::ST_IDLE : pmst_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = pmst_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath control and next values for each state.
    always_comb
    begin
        mem_we        = 1'b0;
        mem_waddr     = clr_addr_reg;
        mem_wdata     = '0;
        mem_re        = 1'b0;
        mem_raddr     = {i_reg, j_reg};
        cmp_ctl.init  = 1'b0;
        cmp_ctl.sample = q_valid_reg && q_qual_reg && (mem_rdata != '0);

        clr_addr_next = clr_addr_reg;
        wr_a_next     = wr_a_reg;
        wr_b_next     = wr_b_reg;
        wr_w_next     = wr_w_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        last_idx_next = last_idx_reg;
        step_next     = step_reg;
        visited_next  = visited_reg;
        cost_next     = cost_reg;
        q_valid_next  = 1'b0;
        q_qual_next   = 1'b0;
        q_row_next    = i_reg;
        q_col_next    = j_reg;

        out_valid_next = out_valid_reg && !out_ch.ready;
        out_from_next  = out_from_reg;
        out_to_next    = out_to_reg;
        out_w_next     = out_w_reg;
        out_cost_next  = out_cost_reg;
        out_none_next  = out_none_reg;
        out_last_next  = out_last_reg;

        unique case (state_reg)
            pmst_pkg::ST_CLEAR:
            begin
                // Zero one entry per cycle.
                mem_we        = 1'b1;
                mem_waddr     = clr_addr_reg;
                clr_addr_next = clr_addr_reg + addr_t'(1);
            end
            pmst_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    priority if (in_ch.op == pmst_pkg::OP_WRITE)
                    begin
                        // First direction now, the mirrored entry next cycle.
                        mem_we    = in_range;
                        mem_waddr = {node_t'(in_ch.node_a), node_t'(in_ch.node_b)};
                        mem_wdata = weight_t'(in_ch.edge_weight);
                        wr_a_next = node_t'(in_ch.node_a);
                        wr_b_next = node_t'(in_ch.node_b);
                        wr_w_next = weight_t'(in_ch.edge_weight);
                    end
                    else if (in_ch.op == pmst_pkg::OP_START)
                    begin
                        visited_next  = MAX_NODES'(1);
                        cost_next     = '0;
                        last_idx_next = start_last;
                        step_next     = '0;
                        i_next        = '0;
                        j_next        = '0;
                        cmp_ctl.init  = 1'b1;
                    end
                    else if (in_ch.op == pmst_pkg::OP_CLEAR)
                    begin
                        clr_addr_next = '0;
                    end
                    else
                    begin
                        // The unused op code is dropped.
                    end
                end
            end
            pmst_pkg::ST_WR2:
            begin
                mem_we    = 1'b1;
                mem_waddr = {wr_b_reg, wr_a_reg};
                mem_wdata = wr_w_reg;
            end
            pmst_pkg::ST_SCAN:
            begin
                // Issue one matrix read per cycle in row-major order.
                mem_re       = 1'b1;
                mem_raddr    = {i_reg, j_reg};
                q_valid_next = 1'b1;
                q_qual_next  = visited_reg[i_reg] && !visited_reg[j_reg];
                if (j_reg == last_idx_reg)
                begin
                    j_next = '0;
                    i_next = i_reg + node_t'(1);
                end
                else
                begin
                    j_next = j_reg + node_t'(1);
                end
            end
            pmst_pkg::ST_SCAN_END:
            begin
                // Last read data is compared at this edge.
            end
            pmst_pkg::ST_PICK:
            begin
                // Fetch the chosen entry; with no edge this is entry 0,0.
                mem_re    = 1'b1;
                mem_raddr = {best_row, best_col};
            end
            pmst_pkg::ST_LOAD:
            begin
                if (out_free)
                begin
                    if (cost_sum > sum_t'(pmst_pkg::COST_MAX))
                    begin
                        cost_next = pmst_pkg::COST_MAX;
                    end
                    else
                    begin
                        cost_next = pmst_pkg::COST_W'(cost_sum);
                    end
                    visited_next       = visited_reg;
                    visited_next[best_col] = 1'b1;
                    out_valid_next = 1'b1;
                    out_from_next  = pmst_pkg::NODE_ID_W'(best_row);
                    out_to_next    = pmst_pkg::NODE_ID_W'(best_col);
                    out_w_next     = pmst_pkg::EDGE_W'(mem_rdata);
                    out_cost_next  = cost_next;
                    out_none_next  = !best_found;
                    out_last_next  = step_last;
                    step_next      = step_reg + node_t'(1);
                    i_next         = '0;
                    j_next         = '0;
                    cmp_ctl.init   = !step_last;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= pmst_pkg::ST_CLEAR;
            node_count_reg <= pmst_pkg::NODE_COUNT_RST;
            clr_addr_reg   <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            last_idx_reg   <= '0;
            step_reg       <= '0;
            visited_reg    <= '0;
            cost_reg       <= '0;
            q_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            last_idx_reg  <= last_idx_next;
            step_reg      <= step_next;
            visited_reg   <= visited_next;
            cost_reg      <= cost_next;
            q_valid_reg   <= q_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                node_count_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        wr_a_reg     <= wr_a_next;
        wr_b_reg     <= wr_b_next;
        wr_w_reg     <= wr_w_next;
        q_qual_reg   <= q_qual_next;
        q_row_reg    <= q_row_next;
        q_col_reg    <= q_col_next;
        out_from_reg <= out_from_next;
        out_to_reg   <= out_to_next;
        out_w_reg    <= out_w_next;
        out_cost_reg <= out_cost_next;
        out_none_reg <= out_none_next;
        out_last_reg <= out_last_next;
    end

    // Channel outputs.
    assign in_ch.ready          = (state_reg == pmst_pkg::ST_IDLE);
    assign out_ch.valid         = out_valid_reg;
    assign out_ch.from_node     = out_from_reg;
    assign out_ch.to_node       = out_to_reg;
    assign out_ch.chosen_weight = out_w_reg;
    assign out_ch.total_cost    = out_cost_reg;
    assign out_ch.no_edge       = out_none_reg;
    assign out_ch.last          = out_last_reg;

endmodule
